@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros shared by the evaluator modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the antecedent
`define PFX_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfx: assertion failed");

// condition holds in the cycle after the antecedent
`define PFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfx: assertion failed");

`endif

@@ design/pfx_pkg.sv @@
// ----------------------------------------------------------------------------
// pfx_pkg
// shared types and constants of the postfix expression evaluator
// ----------------------------------------------------------------------------
package pfx_pkg;

    // characters of the expression
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;
    localparam logic [7:0] CH_POW = 8'h24;

    // status codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
    localparam logic [2:0] ERR_DIVZERO   = 3'd3;
    localparam logic [2:0] ERR_BADTOKEN  = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic load_tok;
        logic push_lit;
        logic rd_ops;
        logic pop;
        logic start;
        logic push_alu;
        logic rd_top;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_op;
        logic last;
        logic unit_done;
        logic out_free;
    } t_sts;

endpackage

@@ design/pfx_div.sv @@
// ----------------------------------------------------------------------------
// pfx_div
// signed 32-bit divider, truncating, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfx_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic        o_dz,
    output logic [31:0] o_quot
);
    import pfx_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_q;
    logic [31:0] r_d;
    logic        r_neg;
    logic        r_dz;

    logic [31:0] w_abs_a;
    logic [31:0] w_abs_b;
    logic [32:0] w_rem_sh;
    logic [33:0] w_diff;
    logic        w_ge;

    assign w_abs_a  = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
    assign w_abs_b  = i_divisor[31]  ? (32'd0 - i_divisor)  : i_divisor;
    assign w_rem_sh = {r_rem[31:0], r_q[31]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_d};
    assign w_ge     = !w_diff[33];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_divisor == 32'd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= w_abs_a;
            r_d   <= w_abs_b;
            r_neg <= i_dividend[31] ^ i_divisor[31];
            r_dz  <= (i_divisor == 32'd0);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[32:0] : w_rem_sh;
            r_q   <= {r_q[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_dz   = r_dz;
    assign o_quot = r_dz ? 32'd0 : (r_neg ? (32'd0 - r_q) : r_q);

    `PFX_ASSERT_SAME(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy)

endmodule

@@ design/pfx_pwr.sv @@
// ----------------------------------------------------------------------------
// pfx_pwr
// wrapping multiply and square-and-multiply power, one exponent bit a cycle
// ----------------------------------------------------------------------------
module pfx_pwr (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_mode_mul,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic        o_dz,
    output logic [31:0] o_res
);
    import pfx_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_acc;
    logic [31:0] r_sq;
    logic [31:0] r_exp;
    logic        r_dz;

    logic [31:0] w_acc_mul;
    logic [31:0] w_sq_mul;
    logic        w_neg_exp;

    assign w_acc_mul = r_acc * r_sq;
    assign w_sq_mul  = r_sq * r_sq;
    assign w_neg_exp = !i_mode_mul && i_b[31];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (w_neg_exp) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= i_mode_mul ? 5'd0 : 5'd31;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dz <= 1'b0;
            if (i_mode_mul) begin
                r_acc <= i_a;
                r_sq  <= i_b;
                r_exp <= 32'd1;
            end else if (i_b[31]) begin
                // truncated real power for a negative exponent
                r_exp <= i_b;
                r_sq  <= i_a;
                if (i_a == 32'd1) begin
                    r_acc <= 32'd1;
                end else if (i_a == 32'hFFFF_FFFF) begin
                    r_acc <= i_b[0] ? 32'hFFFF_FFFF : 32'd1;
                end else begin
                    r_acc <= 32'd0;
                end
                r_dz <= (i_a == 32'd0);
            end else begin
                r_acc <= 32'd1;
                r_sq  <= i_a;
                r_exp <= i_b;
            end
        end else if (r_busy) begin
            if (r_exp[0]) begin
                r_acc <= w_acc_mul;
            end
            r_sq  <= w_sq_mul;
            r_exp <= {1'b0, r_exp[31:1]};
        end
    end

    assign o_done = r_done;
    assign o_dz   = r_dz;
    assign o_res  = r_acc;

endmodule

@@ design/pfx_dp.sv @@
// ----------------------------------------------------------------------------
// pfx_dp
// datapath: token register, operand stack, arithmetic units, result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfx_dp #(
    parameter int STACK_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pfx_pkg::t_cmd  i_cmd,
    output pfx_pkg::t_sts  o_sts,
    input  logic [7:0]     i_tok,
    input  logic           i_last,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [39:0]    o_data
);
    import pfx_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [31:0]   r_mem [STACK_DEPTH];
    logic [7:0]    r_tok;
    logic          r_last;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [2:0]    r_err;
    logic [2:0]    n_err;
    logic [31:0]   r_rd0;
    logic [31:0]   r_rd1;
    logic [31:0]   r_a;
    logic [31:0]   r_b;
    t_op           r_op;
    logic          r_out_valid;
    logic [39:0]   r_out_data;

    logic          w_is_digit;
    logic          w_is_op;
    t_op           w_op;
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_cnt_m2;
    logic          w_full;
    logic          w_push_en;
    logic [31:0]   w_push_val;
    logic [31:0]   w_alu;
    logic          w_alu_dz;
    logic [31:0]   w_cnt_ext;
    logic          w_div_done;
    logic          w_div_dz;
    logic [31:0]   w_div_q;
    logic          w_pwr_done;
    logic          w_pwr_dz;
    logic [31:0]   w_pwr_res;

    function automatic logic [2:0] f_flag(input logic [2:0] cur, input logic [2:0] code);
        f_flag = (cur == ERR_NONE) ? code : cur;
    endfunction

    // token decode
    always_comb begin
        w_is_digit = r_tok inside {[CH_0:CH_9]};
        w_is_op    = r_tok inside {CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW};
        case (r_tok)
            CH_ADD:  w_op = OP_ADD;
            CH_SUB:  w_op = OP_SUB;
            CH_MUL:  w_op = OP_MUL;
            CH_DIV:  w_op = OP_DIV;
            default: w_op = OP_POW;
        endcase
    end

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_full   = (r_count == CW'(STACK_DEPTH));

    // arithmetic units
    pfx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start && (r_op == OP_DIV)),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (w_div_done),
        .o_dz       (w_div_dz),
        .o_quot     (w_div_q)
    );

    pfx_pwr u_pwr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start && ((r_op == OP_MUL) || (r_op == OP_POW))),
        .i_mode_mul (r_op == OP_MUL),
        .i_a        (r_a),
        .i_b        (r_b),
        .o_done     (w_pwr_done),
        .o_dz       (w_pwr_dz),
        .o_res      (w_pwr_res)
    );

    always_comb begin
        case (r_op)
            OP_ADD: begin
                w_alu    = r_a + r_b;
                w_alu_dz = 1'b0;
            end
            OP_SUB: begin
                w_alu    = r_a - r_b;
                w_alu_dz = 1'b0;
            end
            OP_MUL: begin
                w_alu    = w_pwr_res;
                w_alu_dz = 1'b0;
            end
            OP_DIV: begin
                w_alu    = w_div_q;
                w_alu_dz = w_div_dz;
            end
            default: begin
                w_alu    = w_pwr_res;
                w_alu_dz = w_pwr_dz;
            end
        endcase
    end

    assign w_push_en  = i_cmd.push_lit || i_cmd.push_alu;
    assign w_push_val = i_cmd.push_alu ? w_alu :
                        (w_is_digit ? {24'd0, r_tok - CH_0} : 32'd0);

    // stack pointer and first-error tracking
    always_comb begin
        n_count = r_count;
        n_err   = r_err;
        if (i_cmd.pop) begin
            if (r_count >= CW'(2)) begin
                n_count = w_cnt_m2;
            end else begin
                n_count = '0;
                n_err   = f_flag(n_err, ERR_UNDERFLOW);
            end
        end
        if (i_cmd.push_lit && !w_is_digit) begin
            n_err = f_flag(n_err, ERR_BADTOKEN);
        end
        if (i_cmd.push_alu && w_alu_dz) begin
            n_err = f_flag(n_err, ERR_DIVZERO);
        end
        if (w_push_en) begin
            if (w_full) begin
                n_err = f_flag(n_err, ERR_OVERFLOW);
            end else begin
                n_count = r_count + CW'(1);
            end
        end
        if (i_cmd.emit) begin
            n_count = '0;
            n_err   = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_err   <= n_err;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_push_en && !w_full) begin
            r_mem[r_count[AW-1:0]] <= w_push_val;
        end
        if (i_cmd.rd_ops || i_cmd.rd_top) begin
            r_rd0 <= r_mem[w_cnt_m1[AW-1:0]];
        end
        if (i_cmd.rd_ops) begin
            r_rd1 <= r_mem[w_cnt_m2[AW-1:0]];
        end
    end

    assign w_cnt_ext = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tok) begin
            r_tok  <= i_tok;
            r_last <= i_last;
        end
        if (i_cmd.pop) begin
            // a missing operand reads as all ones
            r_b  <= (r_count >= CW'(1)) ? r_rd0 : 32'hFFFF_FFFF;
            r_a  <= (r_count >= CW'(2)) ? r_rd1 : 32'hFFFF_FFFF;
            r_op <= w_op;
        end
        if (i_cmd.emit) begin
            r_out_data[31:0]  <= (r_count != '0) ? r_rd0 : 32'd0;
            r_out_data[36:32] <= w_cnt_ext[4:0];
            r_out_data[39:37] <= r_err;
        end
    end

    assign o_sts.is_op     = w_is_op;
    assign o_sts.last      = r_last;
    assign o_sts.unit_done = (r_op == OP_ADD) || (r_op == OP_SUB) || w_div_done || w_pwr_done;
    assign o_sts.out_free  = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_data          = r_out_data;

    `PFX_ASSERT_SAME(a_dp_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(STACK_DEPTH))
    `PFX_ASSERT_NEXT(a_dp_emit_clears, i_clk, i_rst_n, i_cmd.emit, (r_count == '0) && (r_err == ERR_NONE) && r_out_valid)

endmodule

@@ design/pfx_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfx_ctrl
// sequencer: decode, operand fetch, arithmetic wait, result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  pfx_pkg::t_sts i_sts,
    output pfx_pkg::t_cmd o_cmd
);
    import pfx_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_TOPRD = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_tok = 1'b1;
                    n_state        = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_op) begin
                    o_cmd.rd_ops = 1'b1;
                    n_state      = S_POP;
                end else begin
                    o_cmd.push_lit = 1'b1;
                    n_state        = i_sts.last ? S_TOPRD : S_IDLE;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.start = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.unit_done) begin
                    o_cmd.push_alu = 1'b1;
                    n_state        = i_sts.last ? S_TOPRD : S_IDLE;
                end
            end
            S_TOPRD: begin
                o_cmd.rd_top = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    `PFX_ASSERT_NEXT(a_ctrl_accept_dec, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state == S_DEC)
    `PFX_ASSERT_SAME(a_ctrl_emit_free, i_clk, i_rst_n, o_cmd.emit, i_sts.out_free)

endmodule

@@ design/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// a digit or bad token passes through decode only; operators add pop, exec and wait,
// where / and $ wait out the 32-step divider and power unit unless the divisor is
// zero or the exponent negative. the last token adds top read and a stallable emit.
// i_rst_n (synchronous, active low) empties the stack and clears the status.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats: one character each, tlast marks the end of the expression
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] token
    input  logic        i_s_axis_tlast,   // end_of_expr
    // result beats: one per expression
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [31:0] top_value, [36:32] stack_depth,
                                          // [39:37] status
);
    import pfx_pkg::*;

    // command and status between the sequencer and the datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // the sequencer takes one character at a time; it returns to idle (and
    // ready) once the character is folded into the stack, after the last one once
    // its result is loaded into the output register, where it may still be waiting
    pfx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: operand stack in a two-read one-write memory, the divider,
    // the multiply/power unit, the status tracking and the output register
    pfx_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_tok   (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule
